>>> src/c8cpu_pkg.sv
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Shared types, constants and the hex font for the CHIP-8 core.
// ----------------------------------------------------------------------------
`default_nettype none

package c8cpu_pkg;

  localparam int unsigned AddrW  = 12;
  localparam int unsigned MemBytes = 4096;
  localparam int unsigned ScrW   = 64;
  localparam int unsigned ScrH   = 32;
  localparam int unsigned FontBytes = 80;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0]  KEY_DOWN_NN = 8'h9E;
  localparam logic [7:0]  KEY_UP_NN   = 8'hA1;

  localparam logic [7:0] F_GET_DELAY = 8'h07;
  localparam logic [7:0] F_WAIT_KEY  = 8'h0A;
  localparam logic [7:0] F_SET_DELAY = 8'h15;
  localparam logic [7:0] F_SET_SOUND = 8'h18;
  localparam logic [7:0] F_ADD_I     = 8'h1E;
  localparam logic [7:0] F_GLYPH     = 8'h29;
  localparam logic [7:0] F_BCD       = 8'h33;
  localparam logic [7:0] F_STORE     = 8'h55;
  localparam logic [7:0] F_LOAD      = 8'h65;

  typedef enum logic [2:0] {
    KIND_EXEC  = 3'd0,
    KIND_TICK  = 3'd1,
    KIND_KEY   = 3'd2,
    KIND_LOAD  = 3'd3,
    KIND_ROW   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ALU_PASS_B = 4'd0,
    ALU_OR     = 4'd1,
    ALU_AND    = 4'd2,
    ALU_XOR    = 4'd3,
    ALU_ADD    = 4'd4,
    ALU_SUB    = 4'd5,
    ALU_SHR    = 4'd6,
    ALU_SUBN   = 4'd7,
    ALU_SHL    = 4'd8
  } alu_op_e;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH_HI,
    S_FETCH_LO,
    S_FETCH_WAIT,
    S_RD_X,
    S_RD_Y,
    S_EXEC,
    S_WR_VF,
    S_DRAW_RD,
    S_DRAW_WR,
    S_BCD,
    S_STORE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_DONE
  } state_e;

  localparam logic [7:0] FONT [FontBytes] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

`default_nettype wire

>>> src/c8cpu_alu.sv
// ----------------------------------------------------------------------------
// CHIP-8 ALU
// Shared 8-bit unit for register arithmetic, logic, shifts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module c8cpu_alu (
  input  wire logic [7:0]         a_i,
  input  wire logic [7:0]         b_i,
  input  wire c8cpu_pkg::alu_op_e op_i,
  output c8cpu_pkg::alu_out_t     out_o
);

  logic [8:0] sum;

  always_comb begin
    sum        = {1'b0, a_i} + {1'b0, b_i};
    out_o.res  = b_i;
    out_o.flag = 1'b0;
    out_o.eq   = (a_i == b_i);
    case (op_i)
      c8cpu_pkg::ALU_PASS_B: out_o.res = b_i;
      c8cpu_pkg::ALU_OR:     out_o.res = a_i | b_i;
      c8cpu_pkg::ALU_AND:    out_o.res = a_i & b_i;
      c8cpu_pkg::ALU_XOR:    out_o.res = a_i ^ b_i;
      c8cpu_pkg::ALU_ADD: begin
        out_o.res  = sum[7:0];
        out_o.flag = sum[8];
      end
      c8cpu_pkg::ALU_SUB: begin
        out_o.res  = a_i - b_i;
        out_o.flag = (a_i >= b_i);
      end
      c8cpu_pkg::ALU_SUBN: begin
        out_o.res  = b_i - a_i;
        out_o.flag = (b_i >= a_i);
      end
      c8cpu_pkg::ALU_SHR: begin
        out_o.res  = {1'b0, a_i[7:1]};
        out_o.flag = a_i[0];
      end
      c8cpu_pkg::ALU_SHL: begin
        out_o.res  = {a_i[6:0], 1'b0};
        out_o.flag = a_i[7];
      end
      default: out_o.res = b_i;
    endcase
  end

endmodule

`default_nettype wire

>>> src/chip8_cpu_core.sv
// ----------------------------------------------------------------------------
// CHIP-8 CPU core
// Interpreter core with 4 KiB memory, V registers, stack, timers and display.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Content
// s_axis    in         s_axis_tvalid/tready       one item, kind in tuser
// m_axis    out        m_axis_tvalid/tready       one result per item
// cfg       in         cfg_valid_i/cfg_ready_o    shift_copies_vy bit
//
// Non-execute kinds go from dispatch straight to the result; an instruction
// is fetched, reads VX and VY and executes, plus a VF write state when the
// flag goes to VF. Draws add a read and a write per sprite row and bulk
// register moves a write (store) or a read and a write (load) per register,
// all through the single memory port. After reset the memory is filled with
// the font and zeros, one byte a cycle, during which no item is accepted.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile but waits at its end until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_cpu_core #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned PROGRAM_START = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // keys_down[15:0], key_code[19:16], random_byte[27:20],
  // load_address[39:28], load_value[47:40], row_index[52:48], zero pad
  input  wire logic [55:0] s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // program_counter_out[11:0], waiting_for_key[12], sound_on[13],
  // screen_changed[14], stack_fault[15], screen_row[79:16]
  output logic [79:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  localparam int unsigned SpW  = $clog2(STACK_DEPTH);
  localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = c8cpu_pkg::AddrW;

  // Control state.
  c8cpu_pkg::state_e state_q, state_d;
  logic              clearing_q;
  logic [AW:0]       clr_cnt_q;

  // Latched item.
  logic [2:0]  kind_q;
  logic [15:0] keys_q;
  logic [3:0]  key_q;
  logic [7:0]  rnd_q;
  logic [11:0] laddr_q;
  logic [7:0]  lval_q;
  logic [4:0]  row_q;

  // Architectural state.
  logic [11:0]     pc_q, pc_d;
  logic [15:0]     idx_q, idx_d;
  logic [7:0]      dly_q, dly_d;
  logic [7:0]      snd_q, snd_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            wait_q, wait_d;
  logic [3:0]      wtgt_q, wtgt_d;
  logic            cfg_q;
  logic [7:0]      vregs_q [16];
  logic [11:0]     stack_q [STACK_DEPTH];
  logic [63:0]     disp_q [c8cpu_pkg::ScrH];

  // Working registers.
  logic [7:0]  op_hi_q, op_hi_d, op_lo_q, op_lo_d;
  logic [7:0]  vx_q, vx_d, vy_q, vy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        flag_q, flag_d;
  logic        changed_q, changed_d, fault_q, fault_d;
  logic        tick_snd_q, tick_snd_d;
  logic [63:0] line_q, line_d;

  // Memory port.
  logic [7:0]    mem_q [c8cpu_pkg::MemBytes];
  logic [7:0]    mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  // Register file and display write strobes.
  logic       vreg_we;
  logic [3:0] vreg_waddr, vreg_raddr;
  logic [7:0] vreg_wdata, vreg_rdata;
  logic       disp_clr, disp_we;
  logic [4:0] disp_row;
  logic [63:0] disp_wdata;
  logic       push_we;

  // ALU.
  logic [7:0]           alu_a, alu_b;
  c8cpu_pkg::alu_op_e   alu_op;
  c8cpu_pkg::alu_out_t  alu_out;

  // Decode helpers.
  logic [3:0]  op_top, op_x, op_y, op_n;
  logic [11:0] op_nnn, pc_next, pc_skip;
  logic [15:0] opcode;
  logic        key_held, out_free, accept;
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [3:0]  bcd_t, bcd_o;
  logic [14:0] bcd_prod;
  logic [5:0]  draw_row;
  logic [63:0] spr_mask;
  logic [11:0] idx_off;

  assign opcode  = {op_hi_q, op_lo_q};
  assign op_top  = op_hi_q[7:4];
  assign op_x    = op_hi_q[3:0];
  assign op_y    = op_lo_q[7:4];
  assign op_n    = op_lo_q[3:0];
  assign op_nnn  = {op_hi_q[3:0], op_lo_q};
  assign pc_next = pc_q + 12'd2;
  assign pc_skip = pc_q + 12'd4;
  assign idx_off = idx_q[11:0] + {7'd0, cnt_q};

  assign key_held   = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
  assign vreg_rdata = vregs_q[vreg_raddr];
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state_q == c8cpu_pkg::S_IDLE) && !clearing_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Decimal digits of VX: hundreds by compare, tens by reciprocal multiply.
  always_comb begin
    if (vx_q >= 8'd200) begin
      bcd_h = 2'd2;
    end else if (vx_q >= 8'd100) begin
      bcd_h = 2'd1;
    end else begin
      bcd_h = 2'd0;
    end
    bcd_rem  = 7'(vx_q - 8'(bcd_h) * 8'd100);
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
  end

  // Sprite row placement: the byte is shifted right by the column and
  // anything beyond the right edge simply drops out.
  assign draw_row = {1'b0, vy_q[4:0]} + {1'b0, cnt_q};
  assign spr_mask = {mem_rdata_q, 56'd0} >> vx_q[5:0];

  c8cpu_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .out_o (alu_out)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      c8cpu_pkg::S_IDLE:     if (accept) state_d = c8cpu_pkg::S_DISPATCH;
      c8cpu_pkg::S_DISPATCH: begin
        if (kind_q == c8cpu_pkg::KIND_EXEC && !wait_q) begin
          state_d = c8cpu_pkg::S_FETCH_HI;
        end else begin
          state_d = c8cpu_pkg::S_DONE;
        end
      end
      c8cpu_pkg::S_FETCH_HI:   state_d = c8cpu_pkg::S_FETCH_LO;
      c8cpu_pkg::S_FETCH_LO:   state_d = c8cpu_pkg::S_FETCH_WAIT;
      c8cpu_pkg::S_FETCH_WAIT: state_d = c8cpu_pkg::S_RD_X;
      c8cpu_pkg::S_RD_X:       state_d = c8cpu_pkg::S_RD_Y;
      c8cpu_pkg::S_RD_Y:       state_d = c8cpu_pkg::S_EXEC;
      c8cpu_pkg::S_EXEC: begin
        state_d = c8cpu_pkg::S_DONE;
        case (op_top)
          4'h8: begin
            if (op_n inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) state_d = c8cpu_pkg::S_WR_VF;
          end
          4'hD: state_d = c8cpu_pkg::S_DRAW_RD;
          4'hF: begin
            if (op_lo_q == c8cpu_pkg::F_BCD) state_d = c8cpu_pkg::S_BCD;
            else if (op_lo_q == c8cpu_pkg::F_STORE) state_d = c8cpu_pkg::S_STORE;
            else if (op_lo_q == c8cpu_pkg::F_LOAD) state_d = c8cpu_pkg::S_LOAD_RD;
          end
          default: state_d = c8cpu_pkg::S_DONE;
        endcase
      end
      c8cpu_pkg::S_WR_VF: state_d = c8cpu_pkg::S_DONE;
      c8cpu_pkg::S_DRAW_RD: begin
        if (cnt_q[3:0] == op_n) state_d = c8cpu_pkg::S_WR_VF;
        else state_d = c8cpu_pkg::S_DRAW_WR;
      end
      c8cpu_pkg::S_DRAW_WR: begin
        if (draw_row[5]) state_d = c8cpu_pkg::S_WR_VF;
        else state_d = c8cpu_pkg::S_DRAW_RD;
      end
      c8cpu_pkg::S_BCD:     if (cnt_q == 5'd2) state_d = c8cpu_pkg::S_DONE;
      c8cpu_pkg::S_STORE:   if (cnt_q[3:0] == op_x) state_d = c8cpu_pkg::S_DONE;
      c8cpu_pkg::S_LOAD_RD: state_d = c8cpu_pkg::S_LOAD_WR;
      c8cpu_pkg::S_LOAD_WR: begin
        if (cnt_q[3:0] == op_x) state_d = c8cpu_pkg::S_DONE;
        else state_d = c8cpu_pkg::S_LOAD_RD;
      end
      c8cpu_pkg::S_DONE: if (out_free) state_d = c8cpu_pkg::S_IDLE;
      default: state_d = c8cpu_pkg::S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    pc_d = pc_q;   idx_d = idx_q;   dly_d = dly_q;   snd_d = snd_q;
    lvl_d = lvl_q; wait_d = wait_q; wtgt_d = wtgt_q;
    op_hi_d = op_hi_q; op_lo_d = op_lo_q; vx_d = vx_q; vy_d = vy_q;
    cnt_d = cnt_q; flag_d = flag_q; changed_d = changed_q; fault_d = fault_q;
    tick_snd_d = tick_snd_q; line_d = line_q;
    mem_we = 1'b0; mem_addr = pc_q; mem_wdata = lval_q;
    vreg_we = 1'b0; vreg_waddr = op_x; vreg_wdata = alu_out.res; vreg_raddr = op_x;
    disp_clr = 1'b0; disp_we = 1'b0; disp_row = draw_row[4:0];
    disp_wdata = disp_q[draw_row[4:0]] ^ spr_mask;
    push_we = 1'b0;
    alu_a = vx_q; alu_b = vy_q; alu_op = c8cpu_pkg::ALU_PASS_B;

    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_q[AW-1:0];
      mem_wdata = (clr_cnt_q < (AW+1)'(c8cpu_pkg::FontBytes))
                  ? c8cpu_pkg::FONT[clr_cnt_q[6:0]] : 8'd0;
    end

    case (state_q)
      c8cpu_pkg::S_IDLE: begin
        if (accept) begin
          changed_d = 1'b0;
          fault_d   = 1'b0;
          line_d    = '0;
          cnt_d     = '0;
          flag_d    = 1'b0;
        end
      end
      c8cpu_pkg::S_DISPATCH: begin
        case (kind_q)
          c8cpu_pkg::KIND_TICK: begin
            tick_snd_d = (snd_q != 8'd0);
            if (dly_q != 8'd0) dly_d = dly_q - 8'd1;
            if (snd_q != 8'd0) snd_d = snd_q - 8'd1;
          end
          c8cpu_pkg::KIND_KEY: begin
            if (wait_q) begin
              vreg_we    = 1'b1;
              vreg_waddr = wtgt_q;
              vreg_wdata = {4'd0, key_q};
              wait_d     = 1'b0;
              pc_d       = pc_next;
            end
          end
          c8cpu_pkg::KIND_LOAD: begin
            mem_we    = 1'b1;
            mem_addr  = laddr_q;
            mem_wdata = lval_q;
          end
          c8cpu_pkg::KIND_ROW: line_d = disp_q[row_q];
          default: ;
        endcase
      end
      c8cpu_pkg::S_FETCH_HI: mem_addr = pc_q;
      c8cpu_pkg::S_FETCH_LO: begin
        mem_addr = pc_q + 12'd1;
        op_hi_d  = mem_rdata_q;
      end
      c8cpu_pkg::S_FETCH_WAIT: op_lo_d = mem_rdata_q;
      c8cpu_pkg::S_RD_X: begin
        vreg_raddr = op_x;
        vx_d       = vreg_rdata;
      end
      c8cpu_pkg::S_RD_Y: begin
        vreg_raddr = (op_top == 4'hB) ? 4'd0 : op_y;
        vy_d       = vreg_rdata;
      end
      c8cpu_pkg::S_EXEC: begin
        pc_d = pc_next;
        case (op_top)
          4'h0: begin
            if (opcode == c8cpu_pkg::OP_CLS) begin
              disp_clr  = 1'b1;
              changed_d = 1'b1;
            end else if (opcode == c8cpu_pkg::OP_RET) begin
              if (lvl_q == '0) begin
                fault_d = 1'b1;
              end else begin
                lvl_d = lvl_q - LvlW'(1);
                pc_d  = stack_q[SpW'(lvl_q - LvlW'(1))];
              end
            end
          end
          4'h1: pc_d = op_nnn;
          4'h2: begin
            if (lvl_q >= LvlW'(STACK_DEPTH)) begin
              fault_d = 1'b1;
            end else begin
              push_we = 1'b1;
              lvl_d   = lvl_q + LvlW'(1);
              pc_d    = op_nnn;
            end
          end
          4'h3: begin
            alu_b = op_lo_q;
            if (alu_out.eq) pc_d = pc_skip;
          end
          4'h4: begin
            alu_b = op_lo_q;
            if (!alu_out.eq) pc_d = pc_skip;
          end
          4'h5: if (alu_out.eq) pc_d = pc_skip;
          4'h9: if (!alu_out.eq) pc_d = pc_skip;
          4'h6: begin
            alu_b   = op_lo_q;
            vreg_we = 1'b1;
          end
          4'h7: begin
            alu_b   = op_lo_q;
            alu_op  = c8cpu_pkg::ALU_ADD;
            vreg_we = 1'b1;
          end
          4'h8: begin
            vreg_we = 1'b1;
            case (op_n)
              4'h0: alu_op = c8cpu_pkg::ALU_PASS_B;
              4'h1: alu_op = c8cpu_pkg::ALU_OR;
              4'h2: alu_op = c8cpu_pkg::ALU_AND;
              4'h3: alu_op = c8cpu_pkg::ALU_XOR;
              4'h4: alu_op = c8cpu_pkg::ALU_ADD;
              4'h5: alu_op = c8cpu_pkg::ALU_SUB;
              4'h7: alu_op = c8cpu_pkg::ALU_SUBN;
              4'h6: begin
                alu_op = c8cpu_pkg::ALU_SHR;
                alu_a  = cfg_q ? vy_q : vx_q;
              end
              4'hE: begin
                alu_op = c8cpu_pkg::ALU_SHL;
                alu_a  = cfg_q ? vy_q : vx_q;
              end
              default: vreg_we = 1'b0;
            endcase
            flag_d = alu_out.flag;
          end
          4'hA: idx_d = {4'd0, op_nnn};
          4'hB: pc_d = op_nnn + {4'd0, vy_q};
          4'hC: begin
            alu_a   = rnd_q;
            alu_b   = op_lo_q;
            alu_op  = c8cpu_pkg::ALU_AND;
            vreg_we = 1'b1;
          end
          4'hD: begin
            changed_d = 1'b1;
            flag_d    = 1'b0;
            cnt_d     = '0;
          end
          4'hE: begin
            if (op_lo_q == c8cpu_pkg::KEY_DOWN_NN && key_held) pc_d = pc_skip;
            else if (op_lo_q == c8cpu_pkg::KEY_UP_NN && !key_held) pc_d = pc_skip;
          end
          default: begin
            case (op_lo_q)
              c8cpu_pkg::F_GET_DELAY: begin
                vreg_we    = 1'b1;
                vreg_wdata = dly_q;
              end
              c8cpu_pkg::F_SET_DELAY: dly_d = vx_q;
              c8cpu_pkg::F_SET_SOUND: snd_d = vx_q;
              c8cpu_pkg::F_ADD_I:     idx_d = idx_q + {8'd0, vx_q};
              c8cpu_pkg::F_GLYPH:     idx_d = {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
              c8cpu_pkg::F_WAIT_KEY: begin
                wait_d = 1'b1;
                wtgt_d = op_x;
                pc_d   = pc_q;
              end
              c8cpu_pkg::F_BCD, c8cpu_pkg::F_STORE, c8cpu_pkg::F_LOAD: cnt_d = '0;
              default: pc_d = pc_q;
            endcase
          end
        endcase
      end
      c8cpu_pkg::S_WR_VF: begin
        vreg_we    = 1'b1;
        vreg_waddr = 4'hF;
        vreg_wdata = {7'd0, flag_q};
      end
      c8cpu_pkg::S_DRAW_RD: mem_addr = idx_off;
      c8cpu_pkg::S_DRAW_WR: begin
        if (!draw_row[5]) begin
          disp_we = 1'b1;
          if ((disp_q[draw_row[4:0]] & spr_mask) != 64'd0) flag_d = 1'b1;
          cnt_d = cnt_q + 5'd1;
        end
      end
      c8cpu_pkg::S_BCD: begin
        mem_we   = 1'b1;
        mem_addr = idx_off;
        case (cnt_q[1:0])
          2'd0:    mem_wdata = {6'd0, bcd_h};
          2'd1:    mem_wdata = {4'd0, bcd_t};
          default: mem_wdata = {4'd0, bcd_o};
        endcase
        cnt_d = cnt_q + 5'd1;
      end
      c8cpu_pkg::S_STORE: begin
        vreg_raddr = cnt_q[3:0];
        mem_we     = 1'b1;
        mem_addr   = idx_off;
        mem_wdata  = vreg_rdata;
        cnt_d      = cnt_q + 5'd1;
      end
      c8cpu_pkg::S_LOAD_RD: mem_addr = idx_off;
      c8cpu_pkg::S_LOAD_WR: begin
        vreg_we    = 1'b1;
        vreg_waddr = cnt_q[3:0];
        vreg_wdata = mem_rdata_q;
        cnt_d      = cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  // Memory: one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_addr];
  end

  // Return stack holds no reset value; entries are only read after a push.
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stack_q[lvl_q[SpW-1:0]] <= pc_next;
    end
  end

  // Item latch and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= s_axis_tuser;
      keys_q  <= s_axis_tdata[15:0];
      key_q   <= s_axis_tdata[19:16];
      rnd_q   <= s_axis_tdata[27:20];
      laddr_q <= s_axis_tdata[39:28];
      lval_q  <= s_axis_tdata[47:40];
      row_q   <= s_axis_tdata[52:48];
    end
    op_hi_q    <= op_hi_d;
    op_lo_q    <= op_lo_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    cnt_q      <= cnt_d;
    flag_q     <= flag_d;
    changed_q  <= changed_d;
    fault_q    <= fault_d;
    tick_snd_q <= tick_snd_d;
    line_q     <= line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= c8cpu_pkg::S_IDLE;
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      pc_q       <= AW'(PROGRAM_START);
      idx_q      <= '0;
      dly_q      <= '0;
      snd_q      <= '0;
      lvl_q      <= '0;
      wait_q     <= 1'b0;
      wtgt_q     <= '0;
      cfg_q      <= 1'b1;
      for (int i = 0; i < 16; i++) vregs_q[i] <= '0;
      for (int r = 0; r < c8cpu_pkg::ScrH; r++) disp_q[r] <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      idx_q   <= idx_d;
      dly_q   <= dly_d;
      snd_q   <= snd_d;
      lvl_q   <= lvl_d;
      wait_q  <= wait_d;
      wtgt_q  <= wtgt_d;
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
        if (clr_cnt_q == (AW+1)'(c8cpu_pkg::MemBytes - 1)) clearing_q <= 1'b0;
      end
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (vreg_we) vregs_q[vreg_waddr] <= vreg_wdata;
      if (disp_clr) begin
        for (int r = 0; r < c8cpu_pkg::ScrH; r++) disp_q[r] <= '0;
      end else if (disp_we) begin
        disp_q[disp_row] <= disp_wdata;
      end
      if (state_q == c8cpu_pkg::S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {line_q, fault_q, changed_q,
                          (kind_q == c8cpu_pkg::KIND_TICK) ? tick_snd_q : (snd_q != 8'd0),
                          wait_q, pc_q};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready)
    else $error("item taken during memory fill");

  a_wait_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wait_q) |-> $past(state_q) == c8cpu_pkg::S_EXEC)
    else $error("key wait set outside execution");

  a_pc_moves_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pc_q) |-> ($past(state_q) == c8cpu_pkg::S_EXEC ||
                        $past(state_q) == c8cpu_pkg::S_DISPATCH))
    else $error("program counter changed out of turn");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// CHIP-8 core testbench
// Executes instruction streams and the other item kinds against a
// cycle-free model of the core kept in this file. Every result is compared
// field by field with the model's prediction, under bursty input traffic and
// a patterned output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // Low nibble codes of the 8XYN register operations.
  localparam logic [3:0] NIB_MOV  = 4'h0;
  localparam logic [3:0] NIB_OR   = 4'h1;
  localparam logic [3:0] NIB_AND  = 4'h2;
  localparam logic [3:0] NIB_XOR  = 4'h3;
  localparam logic [3:0] NIB_ADD  = 4'h4;
  localparam logic [3:0] NIB_SUB  = 4'h5;
  localparam logic [3:0] NIB_SHR  = 4'h6;
  localparam logic [3:0] NIB_SUBN = 4'h7;
  localparam logic [3:0] NIB_SHL  = 4'hE;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ProgStart  = 512;

  typedef struct {
    logic [11:0] pc;
    logic        waiting;
    logic        sound;
    logic        changed;
    logic        fault;
    logic [63:0] row;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  chip8_cpu_core #(
    .STACK_DEPTH  (StackDepth),
    .PROGRAM_START(ProgStart)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow state of the core.
  logic [7:0]  shadow_mem [c8cpu_pkg::MemBytes];
  logic [63:0] shadow_screen [c8cpu_pkg::ScrH];
  logic [7:0]  shadow_v [16];
  logic [11:0] shadow_pc;
  logic [15:0] shadow_index;
  logic [7:0]  shadow_delay, shadow_sound;
  logic [11:0] shadow_stack [StackDepth];
  int unsigned shadow_sp;
  logic        shadow_waiting;
  logic [3:0]  shadow_wait_reg;
  logic        shadow_shift_vy;

  outcome_t pending_results [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  task automatic shadow_reset();
    for (int a = 0; a < c8cpu_pkg::MemBytes; a++)
      shadow_mem[a] = (a < c8cpu_pkg::FontBytes) ? c8cpu_pkg::FONT[a] : 8'h00;
    for (int r = 0; r < c8cpu_pkg::ScrH; r++) shadow_screen[r] = '0;
    for (int r = 0; r < 16; r++) shadow_v[r] = '0;
    shadow_pc = ProgStart[11:0];
    shadow_index = '0;
    shadow_delay = '0;
    shadow_sound = '0;
    shadow_sp = 0;
    shadow_waiting = 1'b0;
    shadow_wait_reg = '0;
    shadow_shift_vy = 1'b1;
  endtask

  function automatic bit key_is_held(logic [15:0] keys, logic [7:0] k);
    return (k <= 8'd15) && keys[k[3:0]];
  endfunction

  // Apply one instruction to the shadow state; returns changed/fault.
  task automatic execute_instr(input logic [15:0] keys, input logic [7:0] rnd,
                               output logic changed, output logic fault);
    logic [15:0] op;
    logic [3:0]  top, x, y, n;
    logic [7:0]  nn, a, b;
    logic [11:0] nnn, next_pc, skip_pc, pc;
    logic [8:0]  wide;
    logic [7:0]  bits;
    int unsigned col, row;
    op = {shadow_mem[shadow_pc], shadow_mem[shadow_pc + 12'd1]};
    top = op[15:12]; x = op[11:8]; y = op[7:4]; n = op[3:0];
    nn = op[7:0]; nnn = op[11:0];
    next_pc = shadow_pc + 12'd2;
    skip_pc = shadow_pc + 12'd4;
    pc = next_pc;
    changed = 1'b0;
    fault = 1'b0;
    case (top)
      4'h0: begin
        if (op == c8cpu_pkg::OP_CLS) begin
          for (int r = 0; r < c8cpu_pkg::ScrH; r++) shadow_screen[r] = '0;
          changed = 1'b1;
        end else if (op == c8cpu_pkg::OP_RET) begin
          if (shadow_sp == 0) fault = 1'b1;
          else begin
            shadow_sp--;
            pc = shadow_stack[shadow_sp];
          end
        end
      end
      4'h1: pc = nnn;
      4'h2: begin
        if (shadow_sp >= StackDepth) fault = 1'b1;
        else begin
          shadow_stack[shadow_sp] = next_pc;
          shadow_sp++;
          pc = nnn;
        end
      end
      4'h3: if (shadow_v[x] == nn) pc = skip_pc;
      4'h4: if (shadow_v[x] != nn) pc = skip_pc;
      4'h5: if (shadow_v[x] == shadow_v[y]) pc = skip_pc;
      4'h6: shadow_v[x] = nn;
      4'h7: shadow_v[x] = shadow_v[x] + nn;
      4'h8: begin
        a = shadow_v[x];
        b = shadow_v[y];
        case (n)
          NIB_MOV: shadow_v[x] = b;
          NIB_OR:  shadow_v[x] = a | b;
          NIB_AND: shadow_v[x] = a & b;
          NIB_XOR: shadow_v[x] = a ^ b;
          NIB_ADD: begin
            wide = {1'b0, a} + {1'b0, b};
            shadow_v[x] = wide[7:0];
            shadow_v[15] = {7'd0, wide[8]};
          end
          NIB_SUB: begin
            shadow_v[x] = a - b;
            shadow_v[15] = {7'd0, a >= b};
          end
          NIB_SUBN: begin
            shadow_v[x] = b - a;
            shadow_v[15] = {7'd0, b >= a};
          end
          NIB_SHR: begin
            if (shadow_shift_vy) a = b;
            shadow_v[x] = a >> 1;
            shadow_v[15] = {7'd0, a[0]};
          end
          NIB_SHL: begin
            if (shadow_shift_vy) a = b;
            shadow_v[x] = a << 1;
            shadow_v[15] = {7'd0, a[7]};
          end
          default: ;
        endcase
      end
      4'h9: if (shadow_v[x] != shadow_v[y]) pc = skip_pc;
      4'hA: shadow_index = {4'd0, nnn};
      4'hB: pc = nnn + {4'd0, shadow_v[0]};
      4'hC: shadow_v[x] = rnd & nn;
      4'hD: begin
        col = shadow_v[x] % c8cpu_pkg::ScrW;
        row = shadow_v[y] % c8cpu_pkg::ScrH;
        shadow_v[15] = 8'd0;
        for (int i = 0; i < n; i++) begin
          bits = shadow_mem[shadow_index[11:0] + i[11:0]];
          if (row + i >= c8cpu_pkg::ScrH) break;
          for (int j = 0; j < 8; j++) begin
            if (col + j >= c8cpu_pkg::ScrW) break;
            if (bits[7 - j]) begin
              if (shadow_screen[row + i][63 - (col + j)]) shadow_v[15] = 8'd1;
              shadow_screen[row + i][63 - (col + j)] ^= 1'b1;
            end
          end
        end
        changed = 1'b1;
      end
      4'hE: begin
        if (nn == c8cpu_pkg::KEY_DOWN_NN && key_is_held(keys, shadow_v[x])) pc = skip_pc;
        else if (nn == c8cpu_pkg::KEY_UP_NN && !key_is_held(keys, shadow_v[x])) pc = skip_pc;
      end
      default: begin
        a = shadow_v[x];
        case (nn)
          c8cpu_pkg::F_GET_DELAY: shadow_v[x] = shadow_delay;
          c8cpu_pkg::F_SET_DELAY: shadow_delay = a;
          c8cpu_pkg::F_SET_SOUND: shadow_sound = a;
          c8cpu_pkg::F_ADD_I:     shadow_index = shadow_index + {8'd0, a};
          c8cpu_pkg::F_WAIT_KEY: begin
            shadow_waiting = 1'b1;
            shadow_wait_reg = x;
            pc = shadow_pc;
          end
          c8cpu_pkg::F_GLYPH: shadow_index = {8'd0, a} * 16'd5;
          c8cpu_pkg::F_BCD: begin
            shadow_mem[shadow_index[11:0]]         = a / 100;
            shadow_mem[shadow_index[11:0] + 12'd1] = (a / 10) % 10;
            shadow_mem[shadow_index[11:0] + 12'd2] = a % 10;
          end
          c8cpu_pkg::F_STORE: for (int i = 0; i <= x; i++)
            shadow_mem[shadow_index[11:0] + i[11:0]] = shadow_v[i];
          c8cpu_pkg::F_LOAD: for (int i = 0; i <= x; i++)
            shadow_v[i] = shadow_mem[shadow_index[11:0] + i[11:0]];
          default: pc = shadow_pc;
        endcase
      end
    endcase
    shadow_pc = pc;
  endtask

  task automatic predict_item(input logic [2:0] kind, input logic [15:0] keys,
                              input logic [3:0] key, input logic [7:0] rnd,
                              input logic [11:0] addr, input logic [7:0] val,
                              input logic [4:0] row, output outcome_t res);
    logic chg, flt;
    res.sound = shadow_sound != 0;
    res.changed = 1'b0;
    res.fault = 1'b0;
    res.row = '0;
    case (kind)
      c8cpu_pkg::KIND_EXEC: if (!shadow_waiting) begin
        execute_instr(keys, rnd, chg, flt);
        res.changed = chg;
        res.fault = flt;
      end
      c8cpu_pkg::KIND_TICK: begin
        if (shadow_delay != 0) shadow_delay--;
        if (shadow_sound != 0) shadow_sound--;
      end
      c8cpu_pkg::KIND_KEY: if (shadow_waiting) begin
        shadow_v[shadow_wait_reg] = {4'd0, key};
        shadow_waiting = 1'b0;
        shadow_pc = shadow_pc + 12'd2;
      end
      c8cpu_pkg::KIND_LOAD: shadow_mem[addr] = val;
      c8cpu_pkg::KIND_ROW: res.row = shadow_screen[row];
      default: ;
    endcase
    if (kind != c8cpu_pkg::KIND_TICK) res.sound = shadow_sound != 0;
    res.pc = shadow_pc;
    res.waiting = shadow_waiting;
  endtask

  // Offer one item; returns on the rising edge at which it transfers.
  task automatic send_item(input logic [2:0] kind, input logic [15:0] keys = '0,
                           input logic [3:0] key = '0, input logic [7:0] rnd = '0,
                           input logic [11:0] addr = '0, input logic [7:0] val = '0,
                           input logic [4:0] row = '0);
    outcome_t res;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    predict_item(kind, keys, key, rnd, addr, val, row, res);
    pending_results.push_back(res);
    s_axis_tdata  <= {3'd0, row, val, addr, rnd, key, keys};
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    burst_left--;
  endtask

  // Place an instruction at the current PC and execute it.
  task automatic run_instr(input logic [15:0] op, input logic [15:0] keys = '0,
                           input logic [7:0] rnd = '0);
    send_item(c8cpu_pkg::KIND_LOAD, .addr(shadow_pc), .val(op[15:8]));
    send_item(c8cpu_pkg::KIND_LOAD, .addr(shadow_pc + 12'd1), .val(op[7:0]));
    send_item(c8cpu_pkg::KIND_EXEC, .keys(keys), .rnd(rnd));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_shift_mode(input logic mode);
    drain_results();
    cfg_data_i  <= mode;
    cfg_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_shift_vy = mode;
  endtask

  // Output side: stall pattern rotates through always-ready, random, sparse and bursty phases.
  int unsigned stall_tick = 0;
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 200) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (stall_tick % 4) == 0;
      default: m_axis_tready <= (stall_tick % 32) >= 20;
    endcase
  end

  // Transfers are sampled at the falling edge before they happen, where every signal is settled.
  always @(negedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[11:0] != want.pc) begin
          $display("%0t: pc expected %h actual %h", $time, want.pc, m_axis_tdata[11:0]);
          fail_count++;
        end
        if (m_axis_tdata[12] != want.waiting) begin
          $display("%0t: waiting expected %b actual %b", $time, want.waiting,
                   m_axis_tdata[12]);
          fail_count++;
        end
        if (m_axis_tdata[13] != want.sound) begin
          $display("%0t: sound expected %b actual %b", $time, want.sound, m_axis_tdata[13]);
          fail_count++;
        end
        if (m_axis_tdata[14] != want.changed) begin
          $display("%0t: changed expected %b actual %b", $time, want.changed,
                   m_axis_tdata[14]);
          fail_count++;
        end
        if (m_axis_tdata[15] != want.fault) begin
          $display("%0t: fault expected %b actual %b", $time, want.fault, m_axis_tdata[15]);
          fail_count++;
        end
        if (m_axis_tdata[79:16] != want.row) begin
          $display("%0t: row expected %h actual %h", $time, want.row, m_axis_tdata[79:16]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_plain_kinds();
    send_item(c8cpu_pkg::KIND_ROW, .row(5'd0));
    send_item(c8cpu_pkg::KIND_ROW, .row(5'd31));
    send_item(c8cpu_pkg::KIND_TICK);
    send_item(c8cpu_pkg::KIND_KEY, .key(4'hF));
    send_item(3'd5);
    send_item(3'd7);
    send_item(c8cpu_pkg::KIND_LOAD, .addr(12'hFFF), .val(8'hFF));
  endtask

  task automatic test_registers();
    run_instr(16'h6A05);
    run_instr(16'h6BFF);
    run_instr(16'h7BFF);
    for (int k = 0; k < 16; k++) run_instr({8'h8A, 4'hB, k[3:0]});
    run_instr(16'h6F80);
    run_instr(16'h6380);
    run_instr(16'h8F34);   // flag lands on top of the result
    run_instr(16'hC0FF, '0, 8'hA5);
    run_instr(16'h3A05);
    run_instr(16'h4A05);
    run_instr(16'h5AB0);
    run_instr(16'h9AB0);
    run_instr(16'h0123);   // unknown system call just advances
  endtask

  task automatic test_draw();
    run_instr(16'hA000);
    run_instr(16'h6000);
    run_instr(16'hD005);
    run_instr(16'hD005);   // collision sets VF
    run_instr(16'h6C7E);   // wraps to column 62
    run_instr(16'h6D3E);   // wraps to row 30
    run_instr(16'hDCDF);   // clipped at both edges
    for (int r = 0; r < 32; r++) send_item(c8cpu_pkg::KIND_ROW, .row(r[4:0]));
    run_instr(c8cpu_pkg::OP_CLS);
    send_item(c8cpu_pkg::KIND_ROW, .row(5'd30));
  endtask

  task automatic test_flow();
    run_instr(c8cpu_pkg::OP_RET);     // empty stack
    for (int k = 0; k <= StackDepth; k++) run_instr(16'h2300 + k * 16'h10);
    for (int k = 0; k <= StackDepth; k++) run_instr(c8cpu_pkg::OP_RET);
    run_instr(16'h1FFE);
    run_instr(16'h60FF);
    run_instr(16'hB010);
    run_instr(16'h6107);
    run_instr(16'hE19E, 16'h0080);
    run_instr(16'hE1A1, 16'h0080);
    run_instr(16'hE1A1, 16'hFF7F);
    run_instr(16'hE09E, 16'hFFFF);   // VX above 15 is never held
    run_instr(16'hE0A1, 16'hFFFF);
    run_instr(16'hE055);
  endtask

  task automatic test_misc();
    run_instr(16'h6403);
    run_instr(16'hF415);
    run_instr(16'hF418);
    send_item(c8cpu_pkg::KIND_TICK);
    run_instr(16'hF507);
    repeat (4) send_item(c8cpu_pkg::KIND_TICK);
    run_instr(16'h64FE);
    run_instr(16'hAFFF);
    run_instr(16'hF41E);
    run_instr(16'hF41E);
    run_instr(16'hF433);
    run_instr(16'hFF55);
    run_instr(16'hFF65);
    run_instr(16'hF429);
    run_instr(16'hF4FF);   // unknown: PC stays
    run_instr(16'hF80A);
    send_item(c8cpu_pkg::KIND_EXEC);
    send_item(c8cpu_pkg::KIND_TICK);
    send_item(c8cpu_pkg::KIND_KEY, .key(4'hC));
  endtask

  function automatic logic [15:0] random_instr();
    logic [3:0] top;
    logic [11:0] low;
    logic [7:0] f_codes [10];
    f_codes = '{c8cpu_pkg::F_GET_DELAY, c8cpu_pkg::F_WAIT_KEY, c8cpu_pkg::F_SET_DELAY,
                c8cpu_pkg::F_SET_SOUND, c8cpu_pkg::F_ADD_I, c8cpu_pkg::F_GLYPH,
                c8cpu_pkg::F_BCD, c8cpu_pkg::F_STORE, c8cpu_pkg::F_LOAD, 8'h00};
    top = $urandom_range(0, 15);
    low = $urandom_range(0, 4095);
    case (top)
      4'h0: case ($urandom_range(0, 3))
        0: return c8cpu_pkg::OP_CLS;
        1: return $urandom_range(0, 1) ? c8cpu_pkg::OP_RET : {top, low};
        default: return c8cpu_pkg::OP_RET;
      endcase
      4'h6: if ($urandom_range(0, 1)) low[7:4] = 4'h0;
      4'hE: case ($urandom_range(0, 4))
        0, 1: low[7:0] = c8cpu_pkg::KEY_DOWN_NN;
        2, 3: low[7:0] = c8cpu_pkg::KEY_UP_NN;
        default: ;
      endcase
      4'hF: begin
        low[7:0] = f_codes[$urandom_range(0, 9)];
        if (low[7:0] == 8'h00) low[7:0] = $urandom_range(0, 255);
        if (low[7:0] == c8cpu_pkg::F_WAIT_KEY && $urandom_range(0, 2) != 0)
          low[7:0] = c8cpu_pkg::F_BCD;
      end
      default: ;
    endcase
    return {top, low};
  endfunction

  task automatic test_random(input int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0: send_item(c8cpu_pkg::KIND_TICK);
        1: send_item(c8cpu_pkg::KIND_KEY, .key($urandom_range(0, 15)));
        2: send_item(c8cpu_pkg::KIND_ROW, .row($urandom_range(0, 31)));
        3: send_item(c8cpu_pkg::KIND_LOAD, .addr($urandom_range(0, 4095)),
                     .val($urandom_range(0, 255)));
        4: send_item($urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15),
                     $urandom_range(0, 255), $urandom_range(0, 4095),
                     $urandom_range(0, 255), $urandom_range(0, 31));
        default: begin
          run_instr(random_instr(), $urandom_range(0, 65535), $urandom_range(0, 255));
          sent += 2;
        end
      endcase
      sent++;
    end
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_kinds();
    test_registers();
    write_shift_mode(1'b0);
    run_instr(16'h8AB6);
    run_instr(16'h8ABE);
    write_shift_mode(1'b1);
    test_draw();
    test_flow();
    test_misc();
    test_random(500);
    write_shift_mode(1'b0);
    test_random(500);
    write_shift_mode(1'b1);
    test_random(510);
    drain_results();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
